>>> sv/rgbc_pkg.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution package
// Shared sizes, register indexes and item types of the RGB 3x3 filter.
// ----------------------------------------------------------------------------
package rgbc_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 4096;
   localparam int COEF_FRAC_BITS = 8;

   localparam int PIX_W      = 8;
   localparam int RGB_W      = 3 * PIX_W;
   localparam int COEF_W     = 16;
   localparam int ROW_COEF_W = 3 * COEF_W;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 13;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int IN_ROW_W   = 13;
   localparam int OUT_ROW_W  = 12;
   localparam int CMP_W      = 16;

   localparam int PROD_W = PIX_W + 1 + COEF_W;
   localparam int CSUM_W = PROD_W + 2;
   localparam int TSUM_W = CSUM_W + 2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = ROW_COEF_W;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_TOP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_MID = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_BOT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 3'd4;

   localparam int Q_DEPTH = 8;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int OCC_W   = Q_PTR_W + 1;

   typedef logic [RGB_W-1:0]           pix_type;
   typedef logic [2:0][RGB_W-1:0]      col_type;
   typedef logic [2:0][COEF_W-1:0]     coef_col_type;
   typedef logic signed [CSUM_W-1:0]   csum_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   typedef struct packed {
      logic row_top;
      logic row_bot;
      logic column;
   } cell_mask_type;

   typedef struct packed {
      logic emit;
      logic top;
      logic bot;
      logic left;
      logic right;
      logic last;
   } item_ctl_type;

   typedef struct packed {
      logic [PIX_W-1:0] in_red;
      logic [PIX_W-1:0] in_green;
      logic [PIX_W-1:0] in_blue;
      logic             drain;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_red;
      logic [PIX_W-1:0] out_green;
      logic [PIX_W-1:0] out_blue;
      logic             frame_last;
   } rsp_type;

endpackage

>>> sv/rgbc_cell.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution window cell
// Holds one column of the 3x3 window, passes it to its left neighbor on each
// shift, and forms the registered per-channel column sum of products.
// ----------------------------------------------------------------------------
module rgbc_cell
   import rgbc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  col_type       shift_in,
   output col_type       hand_out,
   input  coef_col_type  coef,
   input  cell_mask_type mask,
   output csum_type      col_sum [3]
);

   col_type                  col_ff;
   col_type                  col_in;
   logic                     row_on [3];
   logic signed [PROD_W-1:0] prod [3][3];
   csum_type                 sum_in [3];
   csum_type                 sum_ff [3];

   assign hand_out = ctrl.clear ? '0 : col_ff;

   always_comb begin
      col_in = col_ff;
      if (ctrl.shift) begin
         col_in = shift_in;
      end else if (ctrl.clear) begin
         col_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

   assign row_on[0] = mask.column & mask.row_top;
   assign row_on[1] = mask.column;
   assign row_on[2] = mask.column & mask.row_bot;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int r = 0; r < 3; r++) begin
            prod[ch][r] = PROD_W'($signed({1'b0, col_ff[r][PIX_W*ch +: PIX_W]})) *
                          PROD_W'($signed(coef[r]));
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_in[ch] = '0;
         for (int r = 0; r < 3; r++) begin
            if (row_on[r]) begin
               sum_in[ch] = sum_in[ch] + CSUM_W'(prod[ch][r]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_ff[ch] <= sum_in[ch];
      end
   end

   assign col_sum = sum_ff;

endmodule

>>> sv/rgbc_linebuf.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution line store
// Two rows of pixels kept as one wide memory with a registered read port,
// written back the cycle after the read, with forwarding for back-to-back
// items at the same column.
// ----------------------------------------------------------------------------
module rgbc_linebuf
   import rgbc_pkg::*;
(
   input  logic             clock,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  pix_type          wr_pix,
   output pix_type          up_pix,
   output pix_type          lo_pix
);

   logic [2*RGB_W-1:0] line_mem_ff [MAX_WIDTH];
   logic [2*RGB_W-1:0] rd_ff;
   logic [2*RGB_W-1:0] byp_ff;
   logic               fwd_ff;

   assign {up_pix, lo_pix} = fwd_ff ? byp_ff : rd_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff  <= line_mem_ff[rd_addr];
         fwd_ff <= wr_en && (wr_addr == rd_addr);
         byp_ff <= {lo_pix, wr_pix};
      end
      if (wr_en) begin
         line_mem_ff[wr_addr] <= {lo_pix, wr_pix};
      end
   end

endmodule

>>> sv/rgb_conv3x3_clamp.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution with zero padding and clamping
// Raster-order RGB pixels in, one 3x3 signed Q7.8 kernel applied to each
// channel, results floored and clamped to 0..255.
// ----------------------------------------------------------------------------
// The block takes one item per clock and keeps doing so while results wait,
// as long as the consumer drains the eight-entry result queue. A pixel's
// result is computed from the item that completes its neighborhood, which
// is the item image_width+1 places later in the stream; so after the last
// pixel of a frame, image_width+1 drain items flush the bottom row. Drain
// items that arrive before the frame is complete are dropped. A result
// passes the line store's registered read, the window shift, the multiply
// stage in the window cells and the final add and clamp. The user must write
// frame size and kernel only while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
module rgb_conv3x3_clamp
   import rgbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [ROW_COEF_W-1:0] coef_top_ff, coef_mid_ff, coef_bot_ff;
   logic [WIDTH_W-1:0]    width_ff;
   logic [HEIGHT_W-1:0]   height_ff;

   logic [COL_W-1:0]      in_col_ff, in_col_in;
   logic [IN_ROW_W-1:0]   in_row_ff, in_row_in;
   logic [COL_W-1:0]      out_col_ff, out_col_in;
   logic [OUT_ROW_W-1:0]  out_row_ff, out_row_in;

   logic [CMP_W-1:0]      w_eff, h_eff;
   logic                  accept, go, frame_done, col_wrap, out_wrap;
   pix_type               a_pix;
   item_ctl_type          a_ctl;

   logic                  s1_valid_ff;
   item_ctl_type          s1_ctl_ff;
   pix_type               s1_pix_ff;
   logic [COL_W-1:0]      s1_ci_ff;
   logic                  s2_valid_ff;
   item_ctl_type          s2_ctl_ff;
   logic                  s3_valid_ff;
   logic                  s3_last_ff;
   logic                  clr_ff;
   logic                  drop;

   pix_type               up_pix, lo_pix;
   col_type               ram_col;
   col_type               hand [3];
   coef_col_type          cell_coef [3];
   cell_ctrl_type         cell_ctrl;
   cell_mask_type         cell_mask [3];
   csum_type              col_sum [3][3];

   logic signed [TSUM_W-1:0] tot [3];
   logic [PIX_W-1:0]         clamped [3];
   rsp_type                  s3_rsp;

   rsp_type               q_ff [Q_DEPTH];
   logic [Q_PTR_W:0]      wptr_ff, rptr_ff;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic                  pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff <= '0;
         coef_mid_ff <= ROW_COEF_W'(1 << (COEF_W + COEF_FRAC_BITS));
         coef_bot_ff <= '0;
         width_ff    <= WIDTH_W'(640);
         height_ff   <= HEIGHT_W'(480);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COEF_TOP: coef_top_ff <= csr_wdata;
            CSR_COEF_MID: coef_mid_ff <= csr_wdata;
            CSR_COEF_BOT: coef_bot_ff <= csr_wdata;
            CSR_WIDTH:    width_ff    <= csr_wdata[WIDTH_W-1:0];
            CSR_HEIGHT:   height_ff   <= csr_wdata[HEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      w_eff = CMP_W'(width_ff);
      if (width_ff == '0) begin
         w_eff = CMP_W'(1);
      end else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end
      h_eff = CMP_W'(height_ff);
      if (height_ff == '0) begin
         h_eff = CMP_W'(1);
      end else if (CMP_W'(height_ff) > CMP_W'(MAX_HEIGHT)) begin
         h_eff = CMP_W'(MAX_HEIGHT);
      end
   end

   // Input side: position tracking and decisions taken when an item arrives.
   assign accept     = req_valid && req_ready;
   assign frame_done = CMP_W'(in_row_ff) >= h_eff;
   assign go         = accept && !(req_data.drain && !frame_done);
   assign col_wrap   = (CMP_W'(in_col_ff) + CMP_W'(1)) >= w_eff;
   assign out_wrap   = (CMP_W'(out_col_ff) + CMP_W'(1)) >= w_eff;
   assign a_pix      = frame_done ? '0 : {req_data.in_blue, req_data.in_green, req_data.in_red};

   always_comb begin
      a_ctl.emit  = (CMP_W'(in_row_ff) >= CMP_W'(2)) ||
                    ((CMP_W'(in_row_ff) == CMP_W'(1)) && (in_col_ff != '0));
      a_ctl.top   = out_row_ff != '0;
      a_ctl.bot   = (CMP_W'(out_row_ff) + CMP_W'(1)) < h_eff;
      a_ctl.left  = out_col_ff != '0;
      a_ctl.right = !out_wrap;
      a_ctl.last  = out_wrap && !a_ctl.bot;
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (go) begin
         if (a_ctl.emit && a_ctl.last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            if (col_wrap) begin
               in_col_in = '0;
               if (in_row_ff != '1) begin
                  in_row_in = in_row_ff + IN_ROW_W'(1);
               end
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
            if (a_ctl.emit) begin
               if (out_wrap) begin
                  out_col_in = '0;
                  if (out_row_ff != '1) begin
                     out_row_in = out_row_ff + OUT_ROW_W'(1);
                  end
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // Pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         clr_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= go;
         s2_valid_ff <= s1_valid_ff && s1_ctl_ff.emit;
         s3_valid_ff <= s2_valid_ff;
         clr_ff      <= s1_valid_ff && s1_ctl_ff.emit && s1_ctl_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff  <= a_ctl;
      s1_pix_ff  <= a_pix;
      s1_ci_ff   <= in_col_ff;
      s2_ctl_ff  <= s1_ctl_ff;
      s3_last_ff <= s2_ctl_ff.last;
   end

   rgbc_linebuf u_linebuf (
      .clock   (clock),
      .rd_en   (go),
      .rd_addr (in_col_ff),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_ci_ff),
      .wr_pix  (s1_pix_ff),
      .up_pix  (up_pix),
      .lo_pix  (lo_pix)
   );

   // Window cells, left to right.
   always_comb begin
      ram_col[0] = up_pix;
      ram_col[1] = lo_pix;
      ram_col[2] = s1_pix_ff;
      for (int k = 0; k < 3; k++) begin
         cell_coef[k][0] = coef_top_ff[COEF_W*k +: COEF_W];
         cell_coef[k][1] = coef_mid_ff[COEF_W*k +: COEF_W];
         cell_coef[k][2] = coef_bot_ff[COEF_W*k +: COEF_W];
         cell_mask[k].row_top = s2_ctl_ff.top;
         cell_mask[k].row_bot = s2_ctl_ff.bot;
      end
      cell_mask[0].column = s2_ctl_ff.left;
      cell_mask[1].column = 1'b1;
      cell_mask[2].column = s2_ctl_ff.right;
      cell_ctrl.shift = s1_valid_ff;
      cell_ctrl.clear = clr_ff;
   end

   rgbc_cell u_cell_left (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (cell_ctrl),
      .shift_in (hand[1]),
      .hand_out (hand[0]),
      .coef     (cell_coef[0]),
      .mask     (cell_mask[0]),
      .col_sum  (col_sum[0])
   );

   rgbc_cell u_cell_center (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (cell_ctrl),
      .shift_in (hand[2]),
      .hand_out (hand[1]),
      .coef     (cell_coef[1]),
      .mask     (cell_mask[1]),
      .col_sum  (col_sum[1])
   );

   rgbc_cell u_cell_right (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (cell_ctrl),
      .shift_in (ram_col),
      .hand_out (hand[2]),
      .coef     (cell_coef[2]),
      .mask     (cell_mask[2]),
      .col_sum  (col_sum[2])
   );

   // Final sum, floor and clamp.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         tot[ch] = TSUM_W'(col_sum[0][ch]) + TSUM_W'(col_sum[1][ch]) +
                   TSUM_W'(col_sum[2][ch]);
         if (tot[ch] <= 0) begin
            clamped[ch] = '0;
         end else if (|tot[ch][TSUM_W-1:COEF_FRAC_BITS+PIX_W]) begin
            clamped[ch] = {PIX_W{1'b1}};
         end else begin
            clamped[ch] = tot[ch][COEF_FRAC_BITS +: PIX_W];
         end
      end
      s3_rsp.out_red    = clamped[0];
      s3_rsp.out_green  = clamped[1];
      s3_rsp.out_blue   = clamped[2];
      s3_rsp.frame_last = s3_last_ff;
   end

   // Result queue and occupancy accounting.
   assign pop       = rsp_valid && rsp_ready;
   assign drop      = s1_valid_ff && !s1_ctl_ff.emit;
   assign rsp_valid = wptr_ff != rptr_ff;
   assign rsp_data  = q_ff[rptr_ff[Q_PTR_W-1:0]];
   assign req_ready = occ_ff < OCC_W'(Q_DEPTH);
   assign occ_in    = occ_ff + OCC_W'(go) - OCC_W'(pop) - OCC_W'(drop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         occ_ff  <= '0;
      end else begin
         occ_ff <= occ_in;
         if (s3_valid_ff) begin
            wptr_ff <= wptr_ff + (Q_PTR_W+1)'(1);
         end
         if (pop) begin
            rptr_ff <= rptr_ff + (Q_PTR_W+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff) begin
         q_ff[wptr_ff[Q_PTR_W-1:0]] <= s3_rsp;
      end
   end

   a_occ_bound : assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(Q_DEPTH))
      else $error("item occupancy exceeds the result queue depth");

   a_queue_room : assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (wptr_ff - rptr_ff) != (Q_PTR_W+1)'(Q_DEPTH))
      else $error("result written into a full queue");

   a_frame_restart : assert property (@(posedge clock) disable iff (reset)
      go && a_ctl.emit && a_ctl.last |=> in_row_ff == '0 && out_row_ff == '0 &&
                                         in_col_ff == '0 && out_col_ff == '0)
      else $error("counters not cleared after the last item of a frame");

   a_result_counted : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> occ_ff != '0)
      else $error("result pending without occupancy");

   a_clear_follows_last : assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> $past(s1_ctl_ff.last) && s2_valid_ff)
      else $error("window clear without a final pixel in flight");

endmodule

>>> tb/sv/rgbc_filter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB 3x3 filter checker
// Follows the register port and the pixel channel of the filter, keeps its
// own copy of the kernel, frame size, line stores, window and frame counters,
// and compares every filtered pixel that leaves the block, field by field,
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module rgbc_filter_checker
   import rgbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    pending,
   output int                    checked
);

   localparam int REPORT_LIMIT = 10;

   logic [ROW_COEF_W-1:0] kernel_rows [3];
   logic [WIDTH_W-1:0]    width_reg;
   logic [HEIGHT_W-1:0]   height_reg;

   pix_type               upper_line [MAX_WIDTH];
   pix_type               lower_line [MAX_WIDTH];
   pix_type               window [9];
   logic [COL_W-1:0]      in_col;
   logic [IN_ROW_W-1:0]   in_row;
   logic [COL_W-1:0]      out_col;
   logic [OUT_ROW_W-1:0]  out_row;

   rsp_type               expected_pixels [$];

   initial begin
      mismatches = 0;
      pending    = 0;
      checked    = 0;
   end

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("[%0t] %s", $time, msg);
      end
   endtask

   task automatic filter_pixel(input req_type item);
      int unsigned         w;
      int unsigned         h;
      int unsigned         slot;
      logic                frame_full;
      logic                emit;
      logic                last;
      logic                vt;
      logic                vb;
      logic                vl;
      logic                vr;
      pix_type             sample;
      pix_type             up;
      pix_type             lo;
      longint              acc;
      logic [PIX_W-1:0]    chan [3];

      w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;

      // A drain item is dropped while the frame still expects pixels.
      frame_full = in_row >= h;
      if (item.drain && !frame_full) begin
         return;
      end
      sample = frame_full ? '0 : {item.in_blue, item.in_green, item.in_red};

      slot = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
      up = upper_line[slot];
      lo = lower_line[slot];
      upper_line[slot] = lo;
      lower_line[slot] = sample;

      for (int r = 0; r < 3; r++) begin
         window[3*r]   = window[3*r+1];
         window[3*r+1] = window[3*r+2];
      end
      window[2] = up;
      window[5] = lo;
      window[8] = sample;

      emit = in_row >= 2 || (in_row == 1 && in_col >= 1);

      if (in_col + 1 >= w) begin
         in_col = '0;
         if (in_row != '1) begin
            in_row++;
         end
      end else begin
         in_col++;
      end

      if (!emit) begin
         return;
      end

      vt = out_row > 0;
      vb = out_row + 1 < h;
      vl = out_col > 0;
      vr = out_col + 1 < w;

      for (int ch = 0; ch < 3; ch++) begin
         acc = 0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               if ((r != 0 || vt) && (r != 2 || vb) && (c != 0 || vl) && (c != 2 || vr)) begin
                  acc += longint'(window[3*r+c][8*ch +: 8])
                         * longint'($signed(kernel_rows[r][16*c +: 16]));
               end
            end
         end
         if (acc <= 0) begin
            chan[ch] = '0;
         end else if ((acc >>> COEF_FRAC_BITS) > 255) begin
            chan[ch] = 8'hFF;
         end else begin
            chan[ch] = acc[COEF_FRAC_BITS +: PIX_W];
         end
      end

      last = out_col + 1 >= w && out_row + 1 >= h;
      expected_pixels.push_back('{out_red: chan[0], out_green: chan[1], out_blue: chan[2],
                                  frame_last: last});

      if (last) begin
         in_col  = '0;
         in_row  = '0;
         out_col = '0;
         out_row = '0;
         foreach (window[i]) window[i] = '0;
      end else if (out_col + 1 >= w) begin
         out_col = '0;
         if (out_row != '1) begin
            out_row++;
         end
      end else begin
         out_col++;
      end
   endtask

   task automatic check_pixel(input rsp_type got);
      rsp_type want;

      if (expected_pixels.size() == 0) begin
         report($sformatf("unexpected pixel r=%02x g=%02x b=%02x last=%0b",
                          got.out_red, got.out_green, got.out_blue, got.frame_last));
         return;
      end
      want = expected_pixels.pop_front();
      checked++;
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue || got.frame_last !== want.frame_last) begin
         report($sformatf("pixel %0d: expected r=%02x g=%02x b=%02x last=%0b, got r=%02x g=%02x b=%02x last=%0b",
                          checked, want.out_red, want.out_green, want.out_blue,
                          want.frame_last, got.out_red, got.out_green, got.out_blue,
                          got.frame_last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kernel_rows[0] = '0;
         kernel_rows[1] = 48'h0000_0100_0000;
         kernel_rows[2] = '0;
         width_reg      = WIDTH_W'(640);
         height_reg     = HEIGHT_W'(480);
         foreach (upper_line[i]) upper_line[i] = '0;
         foreach (lower_line[i]) lower_line[i] = '0;
         foreach (window[i]) window[i] = '0;
         in_col  = '0;
         in_row  = '0;
         out_col = '0;
         out_row = '0;
         expected_pixels.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COEF_TOP: kernel_rows[0] = csr_wdata;
               CSR_COEF_MID: kernel_rows[1] = csr_wdata;
               CSR_COEF_BOT: kernel_rows[2] = csr_wdata;
               CSR_WIDTH:    width_reg  = csr_wdata[WIDTH_W-1:0];
               CSR_HEIGHT:   height_reg = csr_wdata[HEIGHT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            filter_pixel(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            check_pixel(rsp_data);
         end
      end
      pending <= expected_pixels.size();
   end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB 3x3 filter testbench
// Streams frames of RGB pixels through the filter: a few hand-made frames
// with extreme samples, kernels and sizes, then many small frames with
// random kernels, stray drain items and random stalls on both channels.
// A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
   import rgbc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam int IDLE_PCT      = 29;
   localparam int NOISE_PCT     = 5;
   localparam int RANDOM_ITEMS  = 1700;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 20;
   localparam int TIMEOUT_NS    = 5_000_000;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_COEF_TOP;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic                  calm = 1'b0;
   int                    mismatches;
   int                    pending;
   int                    checked;
   int                    items_sent = 0;
   int                    settings = 0;
   int                    random_items = 0;
   int                    w;
   int                    h;
   int                    pause_at;
   logic                  paused_once = 1'b0;
   logic [CSR_DATA_W-1:0] w_data;
   logic [CSR_DATA_W-1:0] h_data;

   rgb_conv3x3_clamp u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rgbc_filter_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending),
      .checked    (checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= calm || $urandom_range(99) >= IDLE_PCT;
   end

   function automatic logic [ROW_COEF_W-1:0] coef_row(input logic [COEF_W-1:0] left,
                                                       input logic [COEF_W-1:0] center,
                                                       input logic [COEF_W-1:0] right);
      return {right, center, left};
   endfunction

   function automatic logic [COEF_W-1:0] random_coef();
      case ($urandom_range(9))
         0: return COEF_W'($urandom);
         1: return '0;
         default: return COEF_W'($urandom_range(384) - 128);
      endcase
   endfunction

   function automatic logic [ROW_COEF_W-1:0] random_row();
      return coef_row(random_coef(), random_coef(), random_coef());
   endfunction

   function automatic req_type pixel(input logic [PIX_W-1:0] red,
                                     input logic [PIX_W-1:0] green,
                                     input logic [PIX_W-1:0] blue);
      return '{in_red: red, in_green: green, in_blue: blue, drain: 1'b0};
   endfunction

   function automatic req_type random_item(input logic drain);
      return '{in_red: PIX_W'($urandom), in_green: PIX_W'($urandom),
               in_blue: PIX_W'($urandom), drain: drain};
   endfunction

   task automatic send_item(input req_type item);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(input logic [ROW_COEF_W-1:0] top_row,
                            input logic [ROW_COEF_W-1:0] mid_row,
                            input logic [ROW_COEF_W-1:0] bot_row,
                            input logic [CSR_DATA_W-1:0] width_data,
                            input logic [CSR_DATA_W-1:0] height_data);
      wait_drained();
      csr_write(CSR_SPARE, CSR_DATA_W'({$urandom, $urandom}));
      csr_write(CSR_COEF_TOP, top_row);
      csr_write(CSR_COEF_MID, mid_row);
      csr_write(CSR_COEF_BOT, bot_row);
      csr_write(CSR_WIDTH, width_data);
      csr_write(CSR_HEIGHT, height_data);
      csr_wr_en <= 1'b0;
      settings++;
   endtask

   // Pixels of one frame with a few stray drains, then the flush items that
   // finish the bottom row; some flush items carry pixels that must be ignored.
   task automatic run_frame(input int cols, input int rows, input int hold_at);
      for (int i = 0; i < cols * rows; i++) begin
         if (i == hold_at) begin
            wait_drained();
         end
         if ($urandom_range(99) < NOISE_PCT) begin
            send_item(random_item(1'b1));
         end
         send_item(random_item(1'b0));
      end
      for (int i = 0; i <= cols; i++) begin
         send_item(random_item($urandom_range(99) >= 25));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Identity kernel on a 3x2 frame with extreme samples, a drain before
      // the frame starts, one in the middle, and a pixel among the flush items.
      configure('0, coef_row('0, 16'h0100, '0), '0, 3, 2);
      send_item(random_item(1'b1));
      send_item(pixel(8'h00, 8'h00, 8'h00));
      send_item(pixel(8'hFF, 8'hFF, 8'hFF));
      send_item(pixel(8'hFF, 8'h00, 8'h80));
      send_item(random_item(1'b1));
      send_item(pixel(8'h01, 8'h7F, 8'hFE));
      send_item(pixel(8'h80, 8'h01, 8'h00));
      send_item(pixel(8'h55, 8'hAA, 8'hFF));
      send_item(random_item(1'b1));
      send_item(pixel(8'h12, 8'h34, 8'h56));
      send_item(random_item(1'b1));
      send_item(random_item(1'b1));

      // Zero width and height act as a single pixel.
      configure('1, coef_row(16'hFFFF, 16'h7FFF, 16'hFFFF), '0, 0, 0);
      send_item(pixel(8'h01, 8'h00, 8'hFF));
      send_item(random_item(1'b1));
      send_item(random_item(1'b1));

      configure(coef_row(16'h8000, 16'hFF00, 16'h0000),
                coef_row(16'hFF00, 16'h0500, 16'hFFFF),
                coef_row(16'h0001, 16'hFF00, 16'h7FFF), 2, 2);
      send_item(pixel(8'hFF, 8'hFF, 8'hFF));
      send_item(pixel(8'h00, 8'h00, 8'h00));
      send_item(pixel(8'hFF, 8'h00, 8'hFF));
      send_item(pixel(8'h10, 8'h20, 8'h30));
      send_item(random_item(1'b1));
      send_item(random_item(1'b1));
      send_item(random_item(1'b1));

      while (random_items < RANDOM_ITEMS) begin
         w = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 0);
         h = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 0);
         w_data = CSR_DATA_W'({$urandom, $urandom});
         h_data = CSR_DATA_W'({$urandom, $urandom});
         w_data[WIDTH_W-1:0]  = WIDTH_W'(w);
         h_data[HEIGHT_W-1:0] = HEIGHT_W'(h);
         if (w == 0) w = 1;
         if (h == 0) h = 1;
         calm <= random_items >= 600 && random_items < 1000;
         configure(random_row(), random_row(), random_row(), w_data, h_data);
         pause_at = -1;
         if (!paused_once || $urandom_range(3) == 0) begin
            pause_at = $urandom_range(w * h - 1);
            paused_once = 1'b1;
         end
         run_frame(w, h, pause_at);
         random_items += w * h + w + 1;
      end

      calm <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Ran %0d kernel and frame settings with stray drains, pauses and stalls,",
               settings);
      $display("with %0d accepted items and %0d filtered pixels compared.",
               items_sent, checked);
      if (mismatches == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d pixels still expected.", pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> files.f
sv/rgbc_pkg.sv
sv/rgbc_cell.sv
sv/rgbc_linebuf.sv
sv/rgb_conv3x3_clamp.sv
tb/sv/rgbc_filter_checker.sv
tb/sv/tb.sv
